// ===== design/gwfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gwfp_pkg: shared types and constants of the gapped window fingerprint core
// Payload structs, modular arithmetic constants and the table of root powers.
// ----------------------------------------------------------------------------
package gwfp_pkg;

    // Field widths fixed by the interface
    localparam int SYM_PORT_W = 8;
    localparam int WS_W       = 16;
    localparam int FP_W       = 31;
    localparam int MASK_W     = 32;
    localparam int RANK_W     = 5;

    // Parameter defaults
    localparam int WINDOW_LEN_DEF  = 32;
    localparam int SYMBOL_BITS_DEF = 8;
    localparam int MAX_LEN_DEF     = 65536;

    // Prime field: P = 15 * 2^27 + 1, so 2^31 = 2^27 - 1 (mod P)
    localparam logic [FP_W-1:0] FP_PRIME = 31'd2013265921;
    localparam logic [FP_W-1:0] FP_ROOT  = 31'd440564289;
    localparam int FOLD_SH = 27;

    // Widths of the product reduction steps
    localparam int PROD_W = SYM_PORT_W + FP_W;   // widest symbol times coefficient
    localparam int V1_W   = 36;                  // after first fold
    localparam int V2_W   = 33;                  // after second fold
    localparam int V3_W   = 32;                  // after third fold

    localparam logic [MASK_W-1:0] MASK_RESET = 32'hFFFF_FFFF;

    typedef logic [MASK_W-1:0][FP_W-1:0] gwfp_pow_tab_t;

    // ROOT^k mod P for k = 0 .. 31, evaluated at elaboration
    function automatic gwfp_pow_tab_t calc_root_pows();
        gwfp_pow_tab_t tab;
        logic [63:0]   pw;
        pw = 64'd1;
        for (int k = 0; k < MASK_W; k++) begin
            tab[k] = pw[FP_W-1:0];
            pw     = (pw * 64'(FP_ROOT)) % 64'(FP_PRIME);
        end
        return tab;
    endfunction

    localparam gwfp_pow_tab_t ROOT_POW = calc_root_pows();

    typedef struct packed {
        logic [SYM_PORT_W-1:0] symbol;
        logic                  new_string;
    } gwfp_in_t;

    typedef struct packed {
        logic [WS_W-1:0] window_start;
        logic [FP_W-1:0] fingerprint;
    } gwfp_out_t;

    // Stage load strobes shared by every cell of the chain
    typedef struct packed {
        logic ld1;        // load product stage
        logic ld2;        // load fold stage
        logic ld3;        // load reduced term stage
        logic chain_upd;  // advance partial sums
        logic chain_clr;  // drop the neighbor's partial sum
        logic win_shift;  // shift the symbol window
    } gwfp_cell_ctl_t;

endpackage

// ===== design/gwfp_coef_gen.sv =====
// ----------------------------------------------------------------------------
// gwfp_coef_gen: projection mask register and per-offset coefficients
// Offset k gets ROOT^(number of mask bits below k) when its mask bit is set,
// and zero otherwise. Coefficients are registered and follow the mask in the cycle after it.
// ----------------------------------------------------------------------------
module gwfp_coef_gen #(
    parameter int WINDOW_LEN = gwfp_pkg::WINDOW_LEN_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [gwfp_pkg::MASK_W-1:0]                  cfg_wdata,
    output logic [WINDOW_LEN-1:0][gwfp_pkg::FP_W-1:0]    coef
);
    import gwfp_pkg::*;

    localparam int LIM = (WINDOW_LEN < MASK_W) ? WINDOW_LEN : MASK_W;

    typedef logic [WINDOW_LEN-1:0][FP_W-1:0] coef_arr_t;

    // Map a mask onto the coefficient of each window offset
    function automatic coef_arr_t calc_coef(input logic [MASK_W-1:0] m);
        coef_arr_t         c;
        logic [RANK_W-1:0] rank;
        c = '0;
        for (int k = 0; k < LIM; k++) begin
            rank = RANK_W'($countones(m & ((MASK_W'(1) << k) - MASK_W'(1))));
            if (m[k])
            begin
                c[k] = ROOT_POW[rank];
            end
        end
        return c;
    endfunction

    logic [MASK_W-1:0] mask_reg;
    coef_arr_t         coef_reg;
    coef_arr_t         coef_next;

    assign coef_next = calc_coef(mask_reg);
    assign coef      = coef_reg;

    // Hold the mask, refresh the coefficients every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
            coef_reg <= calc_coef(MASK_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
            coef_reg <= coef_next;
        end
    end

endmodule

// ===== design/gwfp_cell.sv =====
// ----------------------------------------------------------------------------
// gwfp_cell: one tap of the transposed modular filter
// Holds one window symbol, multiplies the broadcast symbol by its coefficient,
// reduces the product mod P in three steps and adds the neighbor's partial sum.
// ----------------------------------------------------------------------------
module gwfp_cell #(
    parameter int SYM_W = gwfp_pkg::SYMBOL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gwfp_pkg::gwfp_cell_ctl_t      ctl,
    input  logic [SYM_W-1:0]              x,
    input  logic [SYM_W-1:0]              win_in,
    input  logic [gwfp_pkg::FP_W-1:0]     coef,
    input  logic [gwfp_pkg::FP_W-1:0]     sum_in,
    output logic [SYM_W-1:0]              win_out,
    output logic [gwfp_pkg::FP_W-1:0]     sum_out,
    output logic [gwfp_pkg::FP_W-1:0]     sum_next
);
    import gwfp_pkg::*;

    localparam int P_W = SYM_W + FP_W;

    logic [SYM_W-1:0]  win_reg;
    logic [P_W-1:0]    prod_reg;
    logic [V2_W-1:0]   fold_reg;
    logic [FP_W-1:0]   term_reg;
    logic [FP_W-1:0]   sum_reg;

    logic [PROD_W-1:0]      prod_ext;
    logic [SYM_PORT_W-1:0]  hi1;
    logic [V1_W-1:0]        v1;
    logic [V1_W-FP_W-1:0]   hi2;
    logic [V2_W-1:0]        v2;
    logic [V2_W-FP_W-1:0]   hi3;
    logic [V3_W-1:0]        v3;
    logic [FP_W-1:0]        term_next;
    logic [FP_W-1:0]        addend;
    logic [FP_W:0]          acc;

    // First two folds: replace each 2^31 by 2^27 - 1
    always_comb
    begin
        prod_ext = PROD_W'(prod_reg);
        hi1      = prod_ext[PROD_W-1:FP_W];
        v1       = V1_W'(prod_ext[FP_W-1:0]) + (V1_W'(hi1) << FOLD_SH) - V1_W'(hi1);
        hi2      = v1[V1_W-1:FP_W];
        v2       = V2_W'(v1[FP_W-1:0]) + (V2_W'(hi2) << FOLD_SH) - V2_W'(hi2);
    end

    // Last fold and a single subtract bring the term below P
    always_comb
    begin
        hi3 = fold_reg[V2_W-1:FP_W];
        v3  = V3_W'(fold_reg[FP_W-1:0]) + (V3_W'(hi3) << FOLD_SH) - V3_W'(hi3);
        if (v3 >= V3_W'(FP_PRIME))
        begin
            term_next = FP_W'(v3 - V3_W'(FP_PRIME));
        end
        else
        begin
            term_next = v3[FP_W-1:0];
        end
    end

    // Add the neighbor's partial sum mod P
    always_comb
    begin
        addend = ctl.chain_clr ? '0 : sum_in;
        acc    = {1'b0, term_reg} + {1'b0, addend};
        if (acc >= {1'b0, FP_PRIME})
        begin
            sum_next = FP_W'(acc - {1'b0, FP_PRIME});
        end
        else
        begin
            sum_next = acc[FP_W-1:0];
        end
    end

    assign win_out = win_reg;
    assign sum_out = sum_reg;

    // Window symbol and partial sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (ctl.win_shift)
            begin
                win_reg <= win_in;
            end
            if (ctl.chain_upd)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    // Product and reduction stages
    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            prod_reg <= P_W'(x) * P_W'(coef);
        end
        if (ctl.ld2)
        begin
            fold_reg <= v2;
        end
        if (ctl.ld3)
        begin
            term_reg <= term_next;
        end
    end

endmodule

// ===== design/gapped_window_fingerprint_mod_prime_core.sv =====
// ----------------------------------------------------------------------------
// gapped_window_fingerprint_mod_prime_core: sliding gapped window hash mod P
// Streams symbols through a chain of filter cells; each full window yields
// the sum of masked window symbols times successive powers of the root.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid/in_ready    in_data  (symbol, new_string)
//  out       source     out_valid/out_ready  out_data (window_start, fingerprint)
//  cfg       sink       cfg_we               cfg_wdata (projection_mask)
//
//  One symbol per cycle while results are read and no replay runs; a result is
//  valid once the product loaded at the edge that accepts its symbol has passed
//  two reduction stages, then the chain add into the output register.
//  A mask write replays the stored window through the cells to rebuild the
//  partial sums: input is held off after the write until the replay is done.
//  Reset clears window, partial sums and count; the mask returns to all ones.
//  A stalled result freezes the chain once the next result reaches the last
//  stage; outside a replay, input is held off only when the three stages behind it are full.
// ----------------------------------------------------------------------------
module gapped_window_fingerprint_mod_prime_core #(
    parameter int WINDOW_LEN  = gwfp_pkg::WINDOW_LEN_DEF,
    parameter int SYMBOL_BITS = gwfp_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_LEN     = gwfp_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gwfp_pkg::gwfp_in_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gwfp_pkg::gwfp_out_t           out_data,
    input  logic                          cfg_we,
    input  logic [gwfp_pkg::MASK_W-1:0]   cfg_wdata
);
    import gwfp_pkg::*;

    localparam int SYM_W  = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;
    localparam int SEEN_W = $clog2(MAX_LEN + 1);
    localparam int IXC_W  = (SEEN_W > WS_W) ? SEEN_W : WS_W;
    localparam int CNT_W  = $clog2(WINDOW_LEN + 2);
    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    localparam logic [SEEN_W-1:0] MAX_SEEN = SEEN_W'(MAX_LEN);
    localparam logic [SEEN_W-1:0] LEN_SEEN = SEEN_W'(WINDOW_LEN);
    localparam logic [CNT_W-1:0]  LEN_CNT  = CNT_W'(WINDOW_LEN);
    localparam logic [CNT_W-1:0]  WAIT_CNT = CNT_W'(WINDOW_LEN + 1);

    // Cell array wiring
    logic [WINDOW_LEN-1:0][FP_W-1:0] coef;
    logic [SYM_W-1:0]                win_arr  [WINDOW_LEN];
    logic [SYM_W-1:0]                win_feed [WINDOW_LEN];
    logic [FP_W-1:0]                 sum_arr  [WINDOW_LEN];
    logic [FP_W-1:0]                 sum_nx   [WINDOW_LEN];
    gwfp_cell_ctl_t                  cell_ctl;
    logic [SYM_W-1:0]                x_bus;

    // Control state
    logic [SEEN_W-1:0] seen_reg;
    logic [CNT_W-1:0]  rb_cnt_reg;
    logic              s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic              s1_clr_reg, s2_clr_reg, s3_clr_reg;
    logic              s1_emit_reg, s2_emit_reg, s3_emit_reg;
    logic [WS_W-1:0]   s1_ws_reg, s2_ws_reg, s3_ws_reg;
    logic              out_vld_reg;
    gwfp_out_t         out_reg;

    logic [SYM_W-1:0]  sym;
    logic [SEEN_W-1:0] seen_base;
    logic [SEEN_W-1:0] seen_next;
    logic [IXC_W-1:0]  ws_full;
    logic              drop;
    logic              in_fire;
    logic              take;
    logic              rb_busy;
    logic              rb_wait;
    logic              rb_inject;
    logic [IDX_W-1:0]  rb_idx;
    logic              ld1, ld2, ld3, chain_upd;

    // Decode the incoming transaction
    always_comb
    begin
        sym       = in_data.symbol[SYM_W-1:0];
        seen_base = in_data.new_string ? '0 : seen_reg;
        drop      = (seen_base >= MAX_SEEN);
        seen_next = seen_base + SEEN_W'(1);
        ws_full   = IXC_W'(seen_next) - IXC_W'(WINDOW_LEN);
    end

    // Pipeline load strobes, back to front
    assign chain_upd = s3_vld_reg && (!s3_emit_reg || !out_vld_reg || out_ready);
    assign ld3       = chain_upd || !s3_vld_reg;
    assign ld2       = ld3 || !s2_vld_reg;
    assign ld1       = ld2 || !s1_vld_reg;

    // Window replay after a mask write
    assign rb_busy   = (rb_cnt_reg != '0);
    assign rb_wait   = (rb_cnt_reg == WAIT_CNT);
    assign rb_inject = rb_busy && !rb_wait && ld1;
    assign rb_idx    = IDX_W'(LEN_CNT - rb_cnt_reg);

    assign in_ready = ld1 && !rb_busy;
    assign in_fire  = in_valid && in_ready;
    assign take     = in_fire && !drop;

    assign x_bus = rb_inject ? win_arr[rb_idx] : sym;

    always_comb
    begin
        cell_ctl.ld1       = ld1;
        cell_ctl.ld2       = ld2;
        cell_ctl.ld3       = ld3;
        cell_ctl.chain_upd = chain_upd;
        cell_ctl.chain_clr = s3_clr_reg;
        cell_ctl.win_shift = take;
    end

    gwfp_coef_gen #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    // Chain of cells: window shifts toward offset 0, sums toward the last tap
    for (genvar k = 0; k < WINDOW_LEN; k++)
    begin : g_cell
        if (k == WINDOW_LEN - 1)
        begin : g_last
            assign win_feed[k] = sym;
        end
        else
        begin : g_mid
            assign win_feed[k] = in_data.new_string ? '0 : win_arr[k+1];
        end

        if (k == 0)
        begin : g_first
            gwfp_cell #(
                .SYM_W (SYM_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl),
                .x        (x_bus),
                .win_in   (win_feed[k]),
                .coef     (coef[k]),
                .sum_in   ('0),
                .win_out  (win_arr[k]),
                .sum_out  (sum_arr[k]),
                .sum_next (sum_nx[k])
            );
        end
        else
        begin : g_next
            gwfp_cell #(
                .SYM_W (SYM_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl),
                .x        (x_bus),
                .win_in   (win_feed[k]),
                .coef     (coef[k]),
                .sum_in   (sum_arr[k-1]),
                .win_out  (win_arr[k]),
                .sum_out  (sum_arr[k]),
                .sum_next (sum_nx[k])
            );
        end
    end

    // Count, replay counter and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            rb_cnt_reg  <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                seen_reg <= seen_next;
            end

            if (cfg_we)
            begin
                rb_cnt_reg <= WAIT_CNT;
            end
            else if (rb_wait || rb_inject)
            begin
                rb_cnt_reg <= rb_cnt_reg - CNT_W'(1);
            end

            if (ld1)
            begin
                s1_vld_reg <= take || rb_inject;
            end
            if (ld2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (ld3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end

            if (chain_upd && s3_emit_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Sideband that travels with each item, and the result register
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_clr_reg  <= rb_inject ? (rb_cnt_reg == LEN_CNT) : in_data.new_string;
            s1_emit_reg <= !rb_inject && (seen_next >= LEN_SEEN);
            s1_ws_reg   <= ws_full[WS_W-1:0];
        end
        if (ld2)
        begin
            s2_clr_reg  <= s1_clr_reg;
            s2_emit_reg <= s1_emit_reg;
            s2_ws_reg   <= s1_ws_reg;
        end
        if (ld3)
        begin
            s3_clr_reg  <= s2_clr_reg;
            s3_emit_reg <= s2_emit_reg;
            s3_ws_reg   <= s2_ws_reg;
        end
        if (chain_upd && s3_emit_reg)
        begin
            out_reg.window_start <= s3_ws_reg;
            out_reg.fingerprint  <= sum_nx[WINDOW_LEN-1];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    // A mask write holds off input while the partial sums are rebuilt
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input accepted right after a mask write");

    // Results stay inside the field
    a_fp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.fingerprint < FP_PRIME))
        else $error("fingerprint not reduced below the prime");

    // The last stage only waits behind an unread result
    a_chain_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_vld_reg && !chain_upd) |-> (out_vld_reg && !out_ready && s3_emit_reg))
        else $error("chain stalled without an output stall");

    // Replay items never produce a result
    a_replay_silent: assert property (@(posedge clk) disable iff (!rst_n)
        rb_inject |=> !s1_emit_reg)
        else $error("replayed symbol marked to emit");
`endif

endmodule
